// File: src/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared constants, register codes and the logistic table of the speed
// profile generator.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int COUNT_LIMIT            = 30000;
   localparam int LOGISTIC_TABLE_ENTRIES = 256;

   localparam int CNT_W   = 15;
   localparam int IDX_W   = $clog2(LOGISTIC_TABLE_ENTRIES);
   localparam int P_W     = 20 + IDX_W + 1;

   // serial divider and multiplier sizes
   localparam int DIV_W   = 40;
   localparam int DSR_W   = 16;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 31;
   localparam int MUL_P_W = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_TIME  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_COUNT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_STEEPNESS   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_START_SPEED = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_END_SPEED   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_START_STEP  = 3'd5;

   typedef logic [31:0] rom_type [0:LOGISTIC_TABLE_ENTRIES];

   // shift-subtract quotient, used only while building the table
   function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int j = 63; j >= 0; j--) begin
         r = {r[62:0], a[j]};
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // 1 / (1 + e^-t) in Q2.30 at t = i * 16 / ENTRIES
   function automatic rom_type build_rom();
      longint unsigned u;
      longint unsigned term;
      longint unsigned y;
      longint unsigned den;
      longint unsigned t;
      rom_type         r;
      for (int i = 0; i <= LOGISTIC_TABLE_ENTRIES; i++) begin
         t    = udiv64(64'(i) << 20, 64'(LOGISTIC_TABLE_ENTRIES));
         u    = t << 10;
         term = 64'd1 << 31;
         y    = 64'd1 << 31;
         for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * u) >> 31, 64'(k));
            if ((k & 1) == 1) y = y - term;
            else y = y + term;
         end
         for (int k = 0; k < 5; k++)
            y = (y * y + (64'd1 << 30)) >> 31;
         den  = (64'd1 << 31) + y;
         r[i] = 32'(udiv64((64'd1 << 61) + (den >> 1), den));
      end
      return r;
   endfunction

   localparam rom_type LOGISTIC_ROM = build_rom();

endpackage

// File: src/ssp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ssp_pkg::DIV_W-1:0]  dividend,
   input  logic [ssp_pkg::DSR_W-1:0]  divisor,
   output logic                       done,
   output logic [ssp_pkg::DIV_W-1:0]  quotient
);
   import ssp_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DSR_W:0]    trial;
   logic              take;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      take    = trial >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = take ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/ssp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_mul
// Shift-add bit-serial multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ssp_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ssp_pkg::MUL_A_W-1:0] mcand,
   input  logic [ssp_pkg::MUL_B_W-1:0] mplier,
   output logic                        done,
   output logic [ssp_pkg::MUL_P_W-1:0] product
);
   import ssp_pkg::*;

   localparam int CW = $clog2(MUL_B_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [MUL_P_W-1:0] ma_ff, ma_in;
   logic [MUL_B_W-1:0] mb_ff, mb_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ma_in   = MUL_P_W'(mcand);
         mb_in   = mplier;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mb_ff[0]) acc_in = acc_ff + ma_ff;
         ma_in  = {ma_ff[MUL_P_W-2:0], 1'b0};
         mb_in  = {1'b0, mb_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: src/sigmoid_speed_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_speed_profile
// S-curve speed profile: step counter timed by now_ms, logistic table
// lookup with interpolation, scaling between start and end speed.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per control tick: tdata = now_ms, tuser = restart.
//   rsp_* returns one item per request: tdata = speed (Q16.16), tuser =
//   settled. The user must keep csr_* writes to the six registers to
//   times while the block is idle; the block itself does not enforce this.
//   An accepted item passes a serial divide for the advance interval, a
//   serial divide for the logistic argument, a serial multiply for table
//   interpolation and a serial multiply for speed scaling, with sequencing
//   states between, before it shows on rsp_tvalid. When |x| reaches 16
//   the interpolation multiply is skipped. One item is in work at a time;
//   req_tready is high only when idle, so no new item is taken mid-work.
//   The result sits in an output register until rsp_tready takes it; while
//   the receiver stalls, the next item is still accepted and worked, then
//   waits in its last step until the output register empties.
//   Reset (synchronous) restores register defaults, clears the step counter
//   and the last advance time, and empties the output register.
// ----------------------------------------------------------------------------
module sigmoid_speed_profile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] now_ms
   input  logic [0:0]                     req_tuser,   // [0] restart
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // [31:0] speed
   output logic [0:0]                     rsp_tuser,   // [0] settled
   input  logic                           csr_we,
   input  logic [ssp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ssp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV1 = 3'd1;
   localparam logic [2:0] S_ADV  = 3'd2;
   localparam logic [2:0] S_DIV2 = 3'd3;
   localparam logic [2:0] S_MUL1 = 3'd4;
   localparam logic [2:0] S_SPD  = 3'd5;
   localparam logic [2:0] S_MUL2 = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   logic [2:0]        state_ff, state_in;
   logic [31:0]       total_time_ff;
   logic [15:0]       step_count_ff;
   logic [7:0]        steepness_ff;
   logic [31:0]       start_speed_ff;
   logic [31:0]       end_speed_ff;
   logic [CNT_W-1:0]  start_step_ff;

   logic [CNT_W-1:0]  counter_ff, counter_in;
   logic [31:0]       last_ff, last_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       interval_ff, interval_in;
   logic              neg_ff, neg_in;
   logic [31:0]       l0_ff, l0_in;
   logic              up_ff, up_in;
   logic [30:0]       g_ff, g_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       speed_ff, speed_in;
   logic              settled_ff, settled_in;

   logic [15:0]       n;
   logic [14:0]       half;
   logic              advance;
   logic [CNT_W-1:0]  cnt_adv;
   logic              neg_adv;
   logic [14:0]       mag;
   logic [22:0]       smag;
   logic [DIV_W-1:0]  num;

   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend, quo;
   logic [DSR_W-1:0]  div_divisor;
   logic              mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;

   logic              big;
   logic [P_W-1:0]    p;
   logic [IDX_W-1:0]  idx;
   logic [31:0]       l0, l1;
   logic [31:0]       v;
   logic [32:0]       delta;
   logic [32:0]       absd;
   logic [32:0]       pm;
   logic [34:0]       spd;
   logic [34:0]       dd;
   logic              out_free;

   assign n    = (step_count_ff < 16'd2) ? 16'd2 : step_count_ff;
   assign half = n[15:1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_time_ff  <= 32'd1000;
         step_count_ff  <= 16'd100;
         steepness_ff   <= 8'd6;
         start_speed_ff <= '0;
         end_speed_ff   <= '0;
         start_step_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_TOTAL_TIME:  total_time_ff  <= csr_wdata;
            REG_STEP_COUNT:  step_count_ff  <= csr_wdata[15:0];
            REG_STEEPNESS:   steepness_ff   <= csr_wdata[7:0];
            REG_START_SPEED: start_speed_ff <= csr_wdata;
            REG_END_SPEED:   end_speed_ff   <= csr_wdata;
            REG_START_STEP:  start_step_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // advance check and logistic argument
   always_comb begin
      advance = (now_ff - last_ff) >= interval_ff;
      cnt_adv = counter_ff;
      if (advance && counter_ff != CNT_W'(COUNT_LIMIT)) cnt_adv = counter_ff + 1'b1;
      neg_adv = cnt_adv < half;
      mag     = neg_adv ? (half - cnt_adv) : (cnt_adv - half);
      smag    = 23'(steepness_ff) * 23'(mag);
      num     = DIV_W'({smag, 16'd0}) + DIV_W'(half[14:1]);
   end

   // table lookup with the quotient from the second divide
   always_comb begin
      big = quo >= DIV_W'(32'h0010_0000);
      p   = P_W'(quo[19:0]) * P_W'(LOGISTIC_TABLE_ENTRIES);
      idx = p[20 +: IDX_W];
      l0  = LOGISTIC_ROM[idx];
      l1  = LOGISTIC_ROM[IDX_W'(idx) + (IDX_W+1)'(1)];
      v   = up_ff ? (l0_ff + prod[51:20]) : (l0_ff - prod[51:20]);
   end

   // speed scaling
   always_comb begin
      delta = {end_speed_ff[31], end_speed_ff} - {start_speed_ff[31], start_speed_ff};
      absd  = delta[32] ? (33'd0 - delta) : delta;
      pm    = 33'((prod + MUL_P_W'(64'h2000_0000)) >> 30);
      spd   = delta[32] ? ({{3{start_speed_ff[31]}}, start_speed_ff} - {2'b00, pm})
                        : ({{3{start_speed_ff[31]}}, start_speed_ff} + {2'b00, pm});
      dd    = spd - {{3{end_speed_ff[31]}}, end_speed_ff};
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      interval_in  = interval_ff;
      neg_in       = neg_ff;
      l0_in        = l0_ff;
      up_in        = up_ff;
      g_in         = g_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      speed_in     = speed_ff;
      settled_in   = settled_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'(total_time_ff);
      div_divisor  = n;
      mul_start    = 1'b0;
      mul_a        = MUL_A_W'(absd);
      mul_b        = g_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               now_in = req_tdata;
               if (req_tuser[0])
                  counter_in = (start_step_ff > CNT_W'(COUNT_LIMIT)) ?
                               CNT_W'(COUNT_LIMIT) : start_step_ff;
               div_start = 1'b1;
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               interval_in = quo[31:0];
               state_in    = S_ADV;
            end
         end
         S_ADV: begin
            if (advance) last_in = now_ff;
            counter_in   = cnt_adv;
            neg_in       = neg_adv;
            div_dividend = num;
            div_divisor  = {1'b0, half};
            div_start    = 1'b1;
            state_in     = S_DIV2;
         end
         S_DIV2: begin
            if (div_done) begin
               if (big) begin
                  g_in     = neg_ff ? 31'd0 : ONE_Q30;
                  state_in = S_SPD;
               end else begin
                  l0_in     = l0;
                  up_in     = l1 >= l0;
                  mul_a     = MUL_A_W'((l1 >= l0) ? (l1 - l0) : (l0 - l1));
                  mul_b     = MUL_B_W'(p[19:0]);
                  mul_start = 1'b1;
                  state_in  = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            if (mul_done) begin
               g_in     = neg_ff ? (ONE_Q30 - v[30:0]) : v[30:0];
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            mul_start = 1'b1;
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            if (mul_done) state_in = S_DONE;
         end
         S_DONE: begin
            // hold the product until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (dd == 35'd0 || dd == 35'd1 || dd == {35{1'b1}}) begin
                  speed_in   = end_speed_ff;
                  settled_in = 1'b1;
               end else begin
                  speed_in   = spd[31:0];
                  settled_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counter_ff   <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      interval_ff <= interval_in;
      neg_ff      <= neg_in;
      l0_ff       <= l0_in;
      up_ff       <= up_in;
      g_ff        <= g_in;
      speed_ff    <= speed_in;
      settled_ff  <= settled_in;
   end

   ssp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quo)
   );

   ssp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = speed_ff;
   assign rsp_tuser[0] = settled_ff;

endmodule
